[sv/tbe3_pkg.sv]
// Shared types and constants for the threshold + 3x3 binary erosion block.
// Used by tbe3_front, tbe3_queue, tbe3_back and threshold_binary_erosion_3x3.
package tbe3_pkg;

  localparam int GRAY_W = 8;
  localparam int DIM_W  = 11;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;

  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;

  localparam logic [GRAY_W-1:0] THRESHOLD_RST = 8'd100;
  localparam logic [DIM_W-1:0]  WIDTH_RST     = 11'd512;
  localparam logic [DIM_W-1:0]  HEIGHT_RST    = 11'd512;

  localparam logic [GRAY_W-1:0] PIX_FG = 8'hFF;
  localparam logic [GRAY_W-1:0] PIX_BG = 8'h00;

  // result queue between the window stage and the beat sequencer
  localparam int QDEPTH  = 4;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_THRESHOLD = 2'd0,
    CFG_WIDTH     = 2'd1,
    CFG_HEIGHT    = 2'd2
  } cfg_idx_e;

  typedef enum logic {
    MODE_PIXEL = 1'b0,
    MODE_FLUSH = 1'b1
  } mode_e;

  // One queue entry: one or two output beats. The second beat of a pair is
  // the right-edge output, which always erodes to background.
  typedef struct packed {
    logic two;
    logic ero;
    logic last;
  } result_t;

endpackage

[sv/tbe3_front.sv]
// Front part: config registers, row/column/flush counters, threshold, line store
// and 3x3 window. Pushes result entries into the queue. Depends on tbe3_pkg.
module tbe3_front #(
  parameter int MAX_WIDTH  = tbe3_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = tbe3_pkg::DEF_MAX_HEIGHT
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [tbe3_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [tbe3_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic                             mode_i,
  input  logic [tbe3_pkg::GRAY_W-1:0]      gray_pixel_i,
  input  logic [tbe3_pkg::QCNT_W-1:0]      q_count_i,
  output logic                             push_o,
  output tbe3_pkg::result_t                push_data_o
);
  import tbe3_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);

  logic [GRAY_W-1:0] thr_q;
  logic [DIM_W-1:0]  width_q, height_q;
  logic [DIM_W-1:0]  w_eff, h_eff;

  logic [CW-1:0]     col_q;
  logic [RW-1:0]     row_q;
  logic [DIM_W-1:0]  pend_q, pend_clamp;

  logic              clr_busy_q;
  logic [CW-1:0]     clr_addr_q;

  logic              accept, is_flush, fl_has, fl_last;
  logic              last_col, last_row, first, r_ge1, r_ge2, fg_bit;

  // window stage
  logic              b_valid_q, b_flush_q, b_fl_has_q, b_fl_last_q;
  logic              b_bit_q, b_first_q, b_last_col_q, b_rge1_q, b_rge2_q;
  logic [CW-1:0]     b_addr_q;
  logic [8:0]        win_q, win_new;
  logic [1:0]        rd_q, b_wd;
  logic              b_wr, up, mid;

  logic [1:0]        line_mem [MAX_WIDTH];
  logic              mem_we;
  logic [CW-1:0]     mem_wa;
  logic [1:0]        mem_wd;

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q    <= THRESHOLD_RST;
      width_q  <= WIDTH_RST;
      height_q <= HEIGHT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_THRESHOLD: thr_q    <= cfg_data_i[GRAY_W-1:0];
        CFG_WIDTH:     width_q  <= cfg_data_i[DIM_W-1:0];
        CFG_HEIGHT:    height_q <= cfg_data_i[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  // saturate frame size to 1..MAX
  always_comb begin
    if (width_q == '0)                   w_eff = DIM_W'(1);
    else if (32'(width_q) > MAX_WIDTH)   w_eff = DIM_W'(MAX_WIDTH);
    else                                 w_eff = width_q;
    if (height_q == '0)                  h_eff = DIM_W'(1);
    else if (32'(height_q) > MAX_HEIGHT) h_eff = DIM_W'(MAX_HEIGHT);
    else                                 h_eff = height_q;
  end

  // ---------------------------------------------------------------- classify
  assign in_stall_o = clr_busy_q ||
                      ((32'(q_count_i) + 32'(b_valid_q)) >= QDEPTH);
  assign accept     = in_valid_i && !in_stall_o;
  assign is_flush   = (mode_i == MODE_FLUSH);

  assign pend_clamp = (pend_q > w_eff) ? w_eff : pend_q;
  assign fl_has     = (pend_clamp != '0);
  assign fl_last    = (pend_clamp == DIM_W'(1));

  assign last_col = (32'(col_q) + 32'd1) >= 32'(w_eff);
  assign last_row = (32'(row_q) + 32'd1) >= 32'(h_eff);
  assign first    = (col_q == '0);
  assign r_ge1    = (row_q != '0);
  assign r_ge2    = (row_q >= RW'(2));
  assign fg_bit   = (gray_pixel_i > thr_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      pend_q <= '0;
    end else if (accept) begin
      if (is_flush) begin
        pend_q <= fl_has ? pend_clamp - DIM_W'(1) : '0;
      end else if (last_col) begin
        col_q <= '0;
        if (last_row) begin
          row_q  <= '0;
          pend_q <= w_eff;
        end else begin
          row_q  <= row_q + RW'(1);
          pend_q <= '0;
        end
      end else begin
        col_q  <= col_q + CW'(1);
        pend_q <= '0;
      end
    end
  end

  // sweep the line store to zero after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_busy_q) begin
      clr_addr_q <= clr_addr_q + CW'(1);
      if (clr_addr_q == CW'(MAX_WIDTH - 1)) clr_busy_q <= 1'b0;
    end
  end

  // ---------------------------------------------------------------- window stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else begin
      b_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      b_flush_q    <= is_flush;
      b_fl_has_q   <= fl_has;
      b_fl_last_q  <= fl_last;
      b_bit_q      <= fg_bit;
      b_first_q    <= first;
      b_last_col_q <= last_col;
      b_rge1_q     <= r_ge1;
      b_rge2_q     <= r_ge2;
      b_addr_q     <= col_q;
    end
  end

  assign b_wr    = b_valid_q && !b_flush_q;
  assign up      = b_rge2_q && rd_q[1];
  assign mid     = b_rge1_q && rd_q[0];
  assign b_wd    = {mid, b_bit_q};
  assign win_new = {(b_first_q ? 6'b0 : win_q[5:0]), up, mid, b_bit_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= '0;
    end else if (b_wr) begin
      win_q <= win_new;
    end
  end

  // line store: {upper, middle} per column, one read and one write per cycle
  assign mem_we = clr_busy_q || b_wr;
  assign mem_wa = clr_busy_q ? clr_addr_q : b_addr_q;
  assign mem_wd = clr_busy_q ? 2'b00 : b_wd;

  always_ff @(posedge clk_i) begin
    if (mem_we) line_mem[mem_wa] <= mem_wd;
    if (accept) begin
      // forward the write of the item just ahead when it hits the same column
      if (b_wr && (b_addr_q == col_q)) rd_q <= b_wd;
      else                             rd_q <= line_mem[col_q];
    end
  end

  // ---------------------------------------------------------------- push
  always_comb begin
    push_data_o = '0;
    if (b_flush_q) begin
      push_o           = b_valid_q && b_fl_has_q;
      push_data_o.last = b_fl_last_q;
    end else begin
      push_o          = b_valid_q && b_rge1_q && (!b_first_q || b_last_col_q);
      push_data_o.two = b_rge1_q && !b_first_q && b_last_col_q;
      push_data_o.ero = !b_first_q && (&win_new);
    end
  end

endmodule

[sv/tbe3_queue.sv]
// Short result queue between the window stage and the beat sequencer.
// Depends on tbe3_pkg for the entry type and depth.
module tbe3_queue (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push_i,
  input  tbe3_pkg::result_t           push_data_i,
  input  logic                        pop_i,
  output logic [tbe3_pkg::QCNT_W-1:0] count_o,
  output logic                        valid_o,
  output tbe3_pkg::result_t           data_o
);
  import tbe3_pkg::*;

  result_t            slot_q [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0]  cnt_q;
  logic               do_pop;

  assign valid_o = (cnt_q != '0);
  assign data_o  = slot_q[rd_ptr_q];
  assign count_o = cnt_q;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (push_i) slot_q[wr_ptr_q] <= push_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
      if (do_pop) rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
      case ({push_i, do_pop})
        2'b10:   cnt_q <= cnt_q + QCNT_W'(1);
        2'b01:   cnt_q <= cnt_q - QCNT_W'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

[sv/tbe3_back.sv]
// Back part: expands queue entries into output beats and holds them in the
// output register until taken. Depends on tbe3_pkg.
module tbe3_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        q_valid_i,
  input  tbe3_pkg::result_t           q_data_i,
  output logic                        pop_o,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [tbe3_pkg::GRAY_W-1:0] eroded_pixel_o,
  output logic                        frame_last_o
);
  import tbe3_pkg::*;

  logic out_valid_q, ero_q, last_q, sub_q;
  logic load;

  assign load  = q_valid_i && (!out_valid_q || !out_stall_i);
  // pop once the last beat of the entry is loaded
  assign pop_o = load && (!q_data_i.two || sub_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      sub_q       <= 1'b0;
    end else begin
      if (load) begin
        out_valid_q <= 1'b1;
        sub_q       <= q_data_i.two && !sub_q;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      // right-edge beat of a pair is always background
      ero_q  <= sub_q ? 1'b0 : q_data_i.ero;
      last_q <= sub_q ? 1'b0 : q_data_i.last;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign eroded_pixel_o = ero_q ? PIX_FG : PIX_BG;
  assign frame_last_o   = last_q;

endmodule

[sv/threshold_binary_erosion_3x3.sv]
// Thresholded 3x3 binary erosion, one pixel per clock in raster order. A beat is
// taken every cycle while the result queue has room. Output beats lag the input
// by one row and one pixel; each passes the window stage register and the result
// queue and is presented from the output register. The last pixel of a row yields
// two beats and the first pixel yields none, so one beat a cycle is sustained in
// both directions when the output is never stalled. Flush beats (mode 1) emit the
// owed last row, whose final beat carries frame_last. After reset the line store
// is swept to zero, and input is stalled while it is; configuration writes are
// taken at any time.
module threshold_binary_erosion_3x3 #(
  parameter int MAX_WIDTH  = tbe3_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = tbe3_pkg::DEF_MAX_HEIGHT
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [tbe3_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [tbe3_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            mode_i,
  input  logic [tbe3_pkg::GRAY_W-1:0]     gray_pixel_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [tbe3_pkg::GRAY_W-1:0]     eroded_pixel_o,
  output logic                            frame_last_o
);
  import tbe3_pkg::*;

  logic              push, pop, q_valid;
  result_t           push_data, q_data;
  logic [QCNT_W-1:0] q_count;

  tbe3_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .mode_i       (mode_i),
    .gray_pixel_i (gray_pixel_i),
    .q_count_i    (q_count),
    .push_o       (push),
    .push_data_o  (push_data)
  );

  tbe3_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .count_o     (q_count),
    .valid_o     (q_valid),
    .data_o      (q_data)
  );

  tbe3_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_valid_i      (q_valid),
    .q_data_i       (q_data),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .eroded_pixel_o (eroded_pixel_o),
    .frame_last_o   (frame_last_o)
  );

endmodule

[tb/tbe3_erosion_checker.sv]
// Checker for threshold_binary_erosion_3x3: follows register writes and input beats,
// predicts each eroded output beat and compares it with the output channel.
// Depends on tbe3_pkg for widths, register indexes, modes and pixel levels.
module tbe3_erosion_checker
  import tbe3_pkg::*;
#(
  parameter int MAX_W = DEF_MAX_WIDTH,
  parameter int MAX_H = DEF_MAX_HEIGHT
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  input  logic                  in_stall_i,
  input  logic                  mode_i,
  input  logic [GRAY_W-1:0]     gray_pixel_i,
  input  logic                  out_valid_i,
  input  logic                  out_stall_i,
  input  logic [GRAY_W-1:0]     eroded_pixel_i,
  input  logic                  frame_last_i,
  output int                    fail_count_o,
  output int                    result_count_o,
  output int                    outstanding_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [GRAY_W-1:0] pix;
    logic              last;
  } out_beat_t;

  logic [GRAY_W-1:0] thr_q;
  logic [DIM_W-1:0]  width_q;
  logic [DIM_W-1:0]  height_q;
  bit                upper_row [MAX_W];
  bit                middle_row [MAX_W];
  logic [8:0]        win_q;
  int unsigned       row_q;
  int unsigned       col_q;
  int unsigned       owed_q;
  out_beat_t         eroded_fifo [$];
  int                fails;
  int                results;

  assign fail_count_o   = fails;
  assign result_count_o = results;

  function automatic int unsigned clamp_dim(input logic [DIM_W-1:0] v, input int unsigned hi);
    if (v == 0) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic void owe_beat(input logic fg, input logic last);
    out_beat_t b;
    b.pix  = fg ? PIX_FG : PIX_BG;
    b.last = last;
    eroded_fifo.push_back(b);
  endfunction

  task automatic report_mismatch(input string msg);
    fails++;
    if (fails <= 40) $display("[%0t] erosion mismatch: %s", $time, msg);
  endtask

  function automatic void erode_beat(input mode_e m, input logic [GRAY_W-1:0] g);
    int unsigned w;
    int unsigned h;
    int unsigned c;
    int unsigned r;
    logic        up;
    logic        mid;
    logic        fg;
    w = clamp_dim(width_q, MAX_W);
    h = clamp_dim(height_q, MAX_H);
    if (m == MODE_FLUSH) begin
      if (owed_q > w) owed_q = w;
      if (owed_q != 0) begin
        // the padding row below the frame erodes every last-row pixel
        owe_beat(1'b0, owed_q == 1);
        owed_q--;
      end
      return;
    end
    owed_q = 0;
    fg = g > thr_q;
    c  = (col_q >= MAX_W) ? MAX_W - 1 : col_q;
    r  = row_q;
    if (c == 0) win_q = '0;
    // mask stale line store rows above the frame
    up  = (r >= 2) ? upper_row[c] : 1'b0;
    mid = (r >= 1) ? middle_row[c] : 1'b0;
    upper_row[c]  = mid;
    middle_row[c] = fg;
    win_q = {win_q[5:0], up, mid, fg};
    if (r >= 1 && c >= 1) owe_beat(&win_q, 1'b0);
    if (c + 1 >= w) begin
      if (r >= 1) begin
        win_q = {win_q[5:0], 3'b000};
        owe_beat(&win_q, 1'b0);
      end
      col_q = 0;
      if (r + 1 >= h) begin
        row_q  = 0;
        owed_q = w;
      end else begin
        row_q = r + 1;
      end
    end else begin
      col_q = c + 1;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_beat_t want;
    if (!rst_ni) begin
      thr_q    = THRESHOLD_RST;
      width_q  = WIDTH_RST;
      height_q = HEIGHT_RST;
      for (int i = 0; i < MAX_W; i++) begin
        upper_row[i]  = 1'b0;
        middle_row[i] = 1'b0;
      end
      win_q  = '0;
      row_q  = 0;
      col_q  = 0;
      owed_q = 0;
      eroded_fifo.delete();
      outstanding_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_THRESHOLD: thr_q = cfg_data_i[GRAY_W-1:0];
          CFG_WIDTH:     width_q = cfg_data_i;
          CFG_HEIGHT:    height_q = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) erode_beat(mode_e'(mode_i), gray_pixel_i);
      if (out_valid_i && !out_stall_i) begin
        results++;
        if (eroded_fifo.size() == 0) begin
          report_mismatch($sformatf("beat %0d unexpected: eroded_pixel=%0d frame_last=%0b",
                                    results, eroded_pixel_i, frame_last_i));
        end else begin
          want = eroded_fifo.pop_front();
          if (eroded_pixel_i !== want.pix)
            report_mismatch($sformatf("beat %0d eroded_pixel=%0d, want %0d",
                                      results, eroded_pixel_i, want.pix));
          if (frame_last_i !== want.last)
            report_mismatch($sformatf("beat %0d frame_last=%0b, want %0b",
                                      results, frame_last_i, want.last));
        end
      end
      outstanding_o <= eroded_fifo.size();
    end
  end

endmodule

[tb/tb_threshold_binary_erosion_3x3.sv]
// Top of the erosion testbench: clock, reset, register writes, input and output traffic.
// Instantiates threshold_binary_erosion_3x3 and tbe3_erosion_checker; uses tbe3_pkg.
module tb_threshold_binary_erosion_3x3
  import tbe3_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 16;
  localparam int HOLD_CYCLES   = 400;
  localparam int PHASE_BEATS   = 150;
  localparam int IDLE_MIX [4]  = '{0, 80, 0, 10};
  localparam int STALL_MIX [4] = '{0, 0, 80, 10};
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  logic                  clk;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic                  mode = MODE_PIXEL;
  logic [GRAY_W-1:0]     gray = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [GRAY_W-1:0]     eroded;
  logic                  frame_last;

  int          fail_count;
  int          result_count;
  int          outstanding;
  int          idle_pct = 0;
  int          stall_pct = 0;
  int          hold_req = 0;
  int          beats_sent = 0;
  int          useful_beats = 0;
  int          frames = 0;
  int          cfg_writes = 0;
  int unsigned cycle_cnt = 0;

  threshold_binary_erosion_3x3 u_top (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .mode_i         (mode),
    .gray_pixel_i   (gray),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .eroded_pixel_o (eroded),
    .frame_last_o   (frame_last)
  );

  tbe3_erosion_checker u_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_stall_i     (in_stall),
    .mode_i         (mode),
    .gray_pixel_i   (gray),
    .out_valid_i    (out_valid),
    .out_stall_i    (out_stall),
    .eroded_pixel_i (eroded),
    .frame_last_i   (frame_last),
    .fail_count_o   (fail_count),
    .result_count_o (result_count),
    .outstanding_o  (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Output side: random stalls, or a long hold whenever hold_req moves.
  initial begin : receiver
    int hold_left;
    int hold_seen;
    hold_left = 0;
    hold_seen = 0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (hold_seen != hold_req) begin
        hold_seen = hold_req;
        hold_left = HOLD_CYCLES;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  function automatic int eff_dim(input logic [DIM_W-1:0] v, input int hi);
    if (v == 0) return 1;
    return (v > hi) ? hi : int'(v);
  endfunction

  function automatic logic [GRAY_W-1:0] pick_gray(input logic [GRAY_W-1:0] t, input int fg_pct);
    if (t != 8'd255 && $urandom_range(99) < fg_pct)
      return GRAY_W'($urandom_range(255, int'(t) + 1));
    return GRAY_W'($urandom_range(int'(t), 0));
  endfunction

  task automatic send_beat(input mode_e m, input logic [GRAY_W-1:0] g);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    mode     <= m;
    gray     <= g;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    beats_sent++;
  endtask

  // Drop valid, wait for every owed beat, then let the pipeline go quiet.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_writes++;
  endtask

  task automatic configure_frame(input logic [GRAY_W-1:0] t, input logic [DIM_W-1:0] w,
                                 input logic [DIM_W-1:0] h, input bit poke_unused);
    logic [CFG_DATA_W-GRAY_W-1:0] pad;
    pad = (CFG_DATA_W-GRAY_W)'($urandom_range(7));
    write_reg(CFG_THRESHOLD, {pad, t});
    write_reg(CFG_WIDTH, w);
    write_reg(CFG_HEIGHT, h);
    if (poke_unused) write_reg(CFG_UNUSED, CFG_DATA_W'($urandom_range(2047)));
    cfg_we <= 1'b0;
  endtask

  task automatic random_frame(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h,
                              input bit broken);
    logic [GRAY_W-1:0] t;
    int                fg_pct;
    int                wi;
    int                npix;
    int                nflush;
    case ($urandom_range(9))
      0:       t = 8'd0;
      1:       t = 8'd255;
      default: t = GRAY_W'($urandom_range(200, 40));
    endcase
    fg_pct = $urandom_range(98, 60);
    wi     = eff_dim(w, DEF_MAX_WIDTH);
    npix   = wi * eff_dim(h, DEF_MAX_HEIGHT);
    if (broken) npix = $urandom_range(npix, 1);
    settle();
    configure_frame(t, w, h, $urandom_range(7) == 0);
    for (int i = 0; i < npix; i++) begin
      // stray flush: owes nothing unless a frame just ended
      if ($urandom_range(99) < 4) send_beat(MODE_FLUSH, GRAY_W'($urandom_range(255)));
      send_beat(MODE_PIXEL, pick_gray(t, fg_pct));
    end
    useful_beats += npix;
    if (broken) begin
      // a one-by-one frame puts the next frame back on row 0, column 0
      settle();
      configure_frame(t, 11'd1, 11'd1, 1'b0);
      send_beat(MODE_PIXEL, pick_gray(t, fg_pct));
      useful_beats++;
    end else begin
      case ($urandom_range(9))
        0:       nflush = $urandom_range(wi - 1, 0);
        1:       nflush = wi + 2;
        default: nflush = wi;
      endcase
      repeat (nflush) send_beat(MODE_FLUSH, GRAY_W'($urandom_range(255)));
      useful_beats += (nflush < wi) ? nflush : wi;
    end
    frames++;
  endtask

  initial begin : stimulus
    logic [GRAY_W-1:0] frame_a [9];
    logic [GRAY_W-1:0] frame_b [6];
    int unsigned       w;
    int unsigned       h;
    int                phase_mark;
    frame_a = '{8'd101, 8'd255, 8'd200, 8'd150, 8'd101, 8'd255, 8'd255, 8'd180, 8'd101};
    frame_b = '{8'd255, 8'd255, 8'd255, 8'd100, 8'd0, 8'd255};

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // flush with nothing owed
    send_beat(MODE_FLUSH, 8'hA5);
    settle();
    // all-foreground 3x3: only the center survives erosion
    configure_frame(THRESHOLD_RST, 11'd3, 11'd3, 1'b1);
    foreach (frame_a[i]) send_beat(MODE_PIXEL, frame_a[i]);
    // take one owed beat, then let the next frame drop the rest
    send_beat(MODE_FLUSH, 8'h00);
    settle();
    configure_frame(THRESHOLD_RST, 11'd3, 11'd2, 1'b0);
    foreach (frame_b[i]) send_beat(MODE_PIXEL, frame_b[i]);
    // narrow the frame while three beats are owed: only two come out
    settle();
    configure_frame(THRESHOLD_RST, 11'd2, 11'd2, 1'b0);
    repeat (3) send_beat(MODE_FLUSH, 8'hFF);
    // saturated width and zero height, then shrink the width mid-row
    settle();
    configure_frame(8'd0, 11'd2047, 11'd0, 1'b0);
    send_beat(MODE_PIXEL, 8'd0);
    send_beat(MODE_PIXEL, 8'd1);
    send_beat(MODE_PIXEL, 8'd255);
    settle();
    configure_frame(8'd255, 11'd2, 11'd0, 1'b0);
    send_beat(MODE_PIXEL, 8'd255);
    repeat (2) send_beat(MODE_FLUSH, 8'h5A);

    // a wide frame and a tall one
    random_frame(11'd160, 11'd3, 1'b0);
    random_frame(11'd1, 11'd60, 1'b0);

    for (int p = 0; p < 4; p++) begin
      idle_pct  <= IDLE_MIX[p];
      stall_pct <= STALL_MIX[p];
      if (p == 0) begin
        // drain first, then hold the output long enough for the input to back up
        settle();
        hold_req <= hold_req + 1;
        random_frame(11'd8, 11'd6, 1'b0);
      end
      phase_mark = useful_beats;
      while (useful_beats - phase_mark < PHASE_BEATS) begin
        w = ($urandom_range(9) < 8) ? $urandom_range(8, 1) : $urandom_range(40, 9);
        h = ($urandom_range(9) < 8) ? $urandom_range(6, 1) : $urandom_range(20, 7);
        random_frame(DIM_W'(w), DIM_W'(h), $urandom_range(9) < 2);
      end
    end
    settle();

    $display("Sent %0d input beats in %0d frames with %0d register writes,",
             beats_sent, frames, cfg_writes);
    $display("across four idle/stall mixes and one long output hold; %0d result beats checked.",
             result_count);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
